// ===== rtl/core/text_extent_measurer_core_assert.svh =====
// assertion macros shared by the text extent measurer rtl
`ifndef TEXT_EXTENT_MEASURER_CORE_ASSERT_SVH
`define TEXT_EXTENT_MEASURER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tem_pkg.sv =====
// types, codes and microcode program of the text extent measurer
package tem_pkg;

  // request kinds
  localparam logic [1:0] REQ_GLYPH = 2'd0;
  localparam logic [1:0] REQ_KERN  = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SCALE      = 1'b0;
  localparam logic CFG_KERN_COUNT = 1'b1;

  localparam logic [15:0] SCALE_RESET = 16'd256;

  // program steps
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] STEP_IS_GLYPH = 4'd1;
  localparam logic [PC_W-1:0] STEP_IS_KERN  = 4'd2;
  localparam logic [PC_W-1:0] STEP_IS_TEXT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_GSEL     = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_ADV  = 4'd5;
  localparam logic [PC_W-1:0] STEP_ADD_ADV  = 4'd6;
  localparam logic [PC_W-1:0] STEP_HEIGHT   = 4'd7;
  localparam logic [PC_W-1:0] STEP_SCAN     = 4'd8;
  localparam logic [PC_W-1:0] STEP_NO_KERN  = 4'd9;
  localparam logic [PC_W-1:0] STEP_KMUL     = 4'd10;
  localparam logic [PC_W-1:0] STEP_KADD     = 4'd11;
  localparam logic [PC_W-1:0] STEP_PREV     = 4'd12;
  localparam logic [PC_W-1:0] STEP_EMIT     = 4'd13;
  localparam logic [PC_W-1:0] STEP_GWRITE   = 4'd14;
  localparam logic [PC_W-1:0] STEP_KWRITE   = 4'd15;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [8:0]         code;
    logic signed [15:0] advance;
    logic signed [15:0] top_offset;
    logic signed [15:0] glyph_tall;
    logic [7:0]         pair_slot;
    logic [7:0]         pair_first;
    logic [7:0]         pair_second;
    logic signed [15:0] pair_amount;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] text_width;
    logic [38:0]        text_height;
    logic               missing_glyph;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_GSEL,
    OP_MUL_ADV,
    OP_ADD_ADV,
    OP_HEIGHT,
    OP_SCAN,
    OP_KMUL,
    OP_KADD,
    OP_PREV,
    OP_EMIT,
    OP_GWRITE,
    OP_KWRITE
  } op_e;

  // sequencer branch conditions
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_JUMP,
    COND_ACCEPT,
    COND_IF_GLYPH,
    COND_IF_KERN,
    COND_IF_NOT_TEXT,
    COND_IF_NO_KERN,
    COND_SCAN,
    COND_IF_NOT_LAST,
    COND_WAIT_OUT
  } cond_e;

  typedef struct packed {
    logic            ready;
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // control store, one word per step
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{ready: 1'b0, op: OP_NONE, cond: COND_JUMP, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT:     w = '{1'b1, OP_LATCH,   COND_ACCEPT,      STEP_WAIT};
      STEP_IS_GLYPH: w = '{1'b0, OP_NONE,    COND_IF_GLYPH,    STEP_GWRITE};
      STEP_IS_KERN:  w = '{1'b0, OP_NONE,    COND_IF_KERN,     STEP_KWRITE};
      STEP_IS_TEXT:  w = '{1'b0, OP_NONE,    COND_IF_NOT_TEXT, STEP_WAIT};
      STEP_GSEL:     w = '{1'b0, OP_GSEL,    COND_NEXT,        STEP_WAIT};
      STEP_MUL_ADV:  w = '{1'b0, OP_MUL_ADV, COND_NEXT,        STEP_WAIT};
      STEP_ADD_ADV:  w = '{1'b0, OP_ADD_ADV, COND_NEXT,        STEP_WAIT};
      STEP_HEIGHT:   w = '{1'b0, OP_HEIGHT,  COND_IF_NO_KERN,  STEP_PREV};
      STEP_SCAN:     w = '{1'b0, OP_SCAN,    COND_SCAN,        STEP_KMUL};
      STEP_NO_KERN:  w = '{1'b0, OP_NONE,    COND_JUMP,        STEP_PREV};
      STEP_KMUL:     w = '{1'b0, OP_KMUL,    COND_NEXT,        STEP_WAIT};
      STEP_KADD:     w = '{1'b0, OP_KADD,    COND_NEXT,        STEP_WAIT};
      STEP_PREV:     w = '{1'b0, OP_PREV,    COND_IF_NOT_LAST, STEP_WAIT};
      STEP_EMIT:     w = '{1'b0, OP_EMIT,    COND_WAIT_OUT,    STEP_WAIT};
      STEP_GWRITE:   w = '{1'b0, OP_GWRITE,  COND_JUMP,        STEP_WAIT};
      STEP_KWRITE:   w = '{1'b0, OP_KWRITE,  COND_JUMP,        STEP_WAIT};
      default:       w = '{1'b0, OP_NONE,    COND_JUMP,        STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/text_extent_measurer_core.sv =====
// Steps: a load ends in its table write; a text character runs glyph select, advance
// multiply and add, height, an optional kerning search over min(kern_count, KERN_PAIRS)
// slots with multiply and add on a hit, and a previous update; a last character adds emit,
// held on output stall. Throughput: one beat at a time, scan reads one kerning slot a cycle.
// Reset: asynchronous active low; clears sequencer, sums, glyph present bits and output
// valid; scale returns to 1.0 and kern_count to zero. Tables hold garbage until loaded.
module text_extent_measurer_core #(
  parameter int unsigned GLYPH_CODES = 256,
  parameter int unsigned KERN_PAIRS  = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tem_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tem_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import tem_pkg::*;

  localparam int unsigned GIDX_W = $clog2(GLYPH_CODES + 1);
  localparam int unsigned KIDX_W = $clog2(KERN_PAIRS);
  localparam int unsigned LIM_W  = (KIDX_W + 1 > 9) ? KIDX_W + 1 : 9;
  localparam logic [8:0]       GlyphLim   = 9'(GLYPH_CODES);
  localparam logic [8:0]       FallbackCode = 9'd256;
  localparam logic [GIDX_W-1:0] FallbackIdx = GIDX_W'(GLYPH_CODES);
  localparam logic [LIM_W-1:0] KernLim    = LIM_W'(KERN_PAIRS);
  localparam logic signed [39:0] WidthMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] WidthMin = {1'b1, {39{1'b0}}};

  // saturating width accumulate
  function automatic logic signed [39:0] sat_add(input logic signed [39:0] acc,
                                                 input logic signed [33:0] d);
    logic signed [40:0] s;
    s = {acc[39], acc} + {{7{d[33]}}, d};
    if (s[40] != s[39]) begin
      return s[40] ? WidthMin : WidthMax;
    end
    return s[39:0];
  endfunction

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      ctrl;
  logic            in_acc;
  logic            out_busy;
  logic            kmatch;
  logic            scan_done;
  logic            in_range;
  logic            no_kern;

  // configuration
  logic [15:0] scale_q;
  logic [8:0]  kern_count_q;

  // item and per-string state
  in_item_t           item_q;
  logic signed [39:0] width_q;
  logic [38:0]        height_q;
  logic [7:0]         prev_char_q;
  logic               prev_valid_q;
  logic               miss_q;

  // glyph tables
  logic [GLYPH_CODES:0] glyph_present_q;
  logic [15:0]          glyph_adv_mem  [GLYPH_CODES+1];
  logic [15:0]          glyph_top_mem  [GLYPH_CODES+1];
  logic [15:0]          glyph_tall_mem [GLYPH_CODES+1];
  logic [15:0]          adv_rd_q, top_rd_q, tall_rd_q;
  logic                 own_hit, fb_hit;
  logic [GIDX_W-1:0]    gsel_idx;
  logic [GIDX_W-1:0]    gload_idx;
  logic                 gload_ok;
  logic                 g_hit_q;

  // kerning tables
  logic [7:0]        kern_first_mem  [KERN_PAIRS];
  logic [7:0]        kern_second_mem [KERN_PAIRS];
  logic [15:0]       kern_amount_mem [KERN_PAIRS];
  logic [7:0]        kfirst_rd_q, ksecond_rd_q;
  logic [15:0]       kamount_rd_q;
  logic [LIM_W-1:0]  k_q;
  logic [LIM_W-1:0]  kern_lim;
  logic              rd_valid_q;
  logic              kern_rd_en;
  logic              kload_ok;

  // arithmetic
  logic signed [16:0] sum_tb_q;
  logic signed [16:0] mul_a;
  logic signed [33:0] mul_p;
  logic signed [33:0] prod_q;

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  // control word and handshake
  always_comb begin
    ctrl       = ucode_rom(pc_q);
    in_acc     = in_valid_i && ctrl.ready;
    in_stall_o = !ctrl.ready;
    out_busy   = out_valid_q && out_stall_i;
    in_range   = !item_q.code[8];
    no_kern    = !(prev_valid_q && in_range);
  end

  // kerning scan status
  always_comb begin
    kern_lim   = (LIM_W'(kern_count_q) < KernLim) ? LIM_W'(kern_count_q) : KernLim;
    kmatch     = rd_valid_q && (kfirst_rd_q == prev_char_q)
                 && (ksecond_rd_q == item_q.code[7:0]);
    scan_done  = !rd_valid_q && (k_q >= kern_lim);
    kern_rd_en = (ctrl.op == OP_SCAN) && !kmatch;
  end

  // next step
  always_comb begin
    pc_d = pc_q + 1'b1;
    unique case (ctrl.cond)
      COND_NEXT:        pc_d = pc_q + 1'b1;
      COND_JUMP:        pc_d = ctrl.target;
      COND_ACCEPT:      pc_d = in_acc ? pc_q + 1'b1 : pc_q;
      COND_IF_GLYPH:    pc_d = (item_q.req_type == REQ_GLYPH) ? ctrl.target : pc_q + 1'b1;
      COND_IF_KERN:     pc_d = (item_q.req_type == REQ_KERN) ? ctrl.target : pc_q + 1'b1;
      COND_IF_NOT_TEXT: pc_d = (item_q.req_type != REQ_TEXT) ? ctrl.target : pc_q + 1'b1;
      COND_IF_NO_KERN:  pc_d = no_kern ? ctrl.target : pc_q + 1'b1;
      COND_SCAN:        pc_d = kmatch ? ctrl.target : (scan_done ? pc_q + 1'b1 : pc_q);
      COND_IF_NOT_LAST: pc_d = !item_q.last ? ctrl.target : pc_q + 1'b1;
      COND_WAIT_OUT:    pc_d = out_busy ? pc_q : ctrl.target;
      default:          pc_d = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= SCALE_RESET;
      kern_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE:      scale_q      <= cfg_data_i;
        CFG_KERN_COUNT: kern_count_q <= cfg_data_i[8:0];
        default:        ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  // glyph selection and load address
  always_comb begin
    own_hit   = (item_q.code < GlyphLim) && glyph_present_q[GIDX_W'(item_q.code)];
    fb_hit    = glyph_present_q[FallbackIdx];
    gsel_idx  = own_hit ? GIDX_W'(item_q.code) : FallbackIdx;
    gload_ok  = (item_q.code == FallbackCode) || (item_q.code < GlyphLim);
    gload_idx = (item_q.code == FallbackCode) ? FallbackIdx : GIDX_W'(item_q.code);
    kload_ok  = LIM_W'(item_q.pair_slot) < KernLim;
  end

  // glyph present bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_present_q <= '0;
    end else if (ctrl.op == OP_GWRITE && gload_ok) begin
      glyph_present_q[gload_idx] <= 1'b1;
    end
  end

  // glyph metric memory
  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_GWRITE && gload_ok) begin
      glyph_adv_mem[gload_idx]  <= item_q.advance;
      glyph_top_mem[gload_idx]  <= item_q.top_offset;
      glyph_tall_mem[gload_idx] <= item_q.glyph_tall;
    end
    if (ctrl.op == OP_GSEL) begin
      adv_rd_q  <= glyph_adv_mem[gsel_idx];
      top_rd_q  <= glyph_top_mem[gsel_idx];
      tall_rd_q <= glyph_tall_mem[gsel_idx];
      g_hit_q   <= own_hit || fb_hit;
    end
  end

  // kerning pair memory
  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_KWRITE && kload_ok) begin
      kern_first_mem[KIDX_W'(item_q.pair_slot)]  <= item_q.pair_first;
      kern_second_mem[KIDX_W'(item_q.pair_slot)] <= item_q.pair_second;
      kern_amount_mem[KIDX_W'(item_q.pair_slot)] <= item_q.pair_amount;
    end
    if (kern_rd_en) begin
      kfirst_rd_q  <= kern_first_mem[k_q[KIDX_W-1:0]];
      ksecond_rd_q <= kern_second_mem[k_q[KIDX_W-1:0]];
      kamount_rd_q <= kern_amount_mem[k_q[KIDX_W-1:0]];
    end
  end

  // scan pointer and read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= kern_rd_en && (k_q < kern_lim);
      if (ctrl.op == OP_HEIGHT) begin
        k_q <= '0;
      end else if (kern_rd_en && (k_q < kern_lim)) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // shared multiplier, operand picked by the step
  always_comb begin
    case (ctrl.op)
      OP_MUL_ADV: mul_a = {adv_rd_q[15], adv_rd_q};
      OP_ADD_ADV: mul_a = sum_tb_q;
      default:    mul_a = {kamount_rd_q[15], kamount_rd_q};
    endcase
    mul_p = mul_a * $signed({1'b0, scale_q});
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      OP_MUL_ADV: begin
        prod_q   <= mul_p;
        sum_tb_q <= {top_rd_q[15], top_rd_q} + {tall_rd_q[15], tall_rd_q};
      end
      OP_ADD_ADV, OP_KMUL: prod_q <= mul_p;
      default: ;
    endcase
  end

  // per-string accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= '0;
      height_q     <= '0;
      prev_char_q  <= '0;
      prev_valid_q <= 1'b0;
      miss_q       <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_GSEL: begin
          if (!(own_hit || fb_hit)) begin
            miss_q <= 1'b1;
          end
        end
        OP_ADD_ADV: begin
          if (g_hit_q) begin
            width_q <= sat_add(width_q, prod_q);
          end
        end
        OP_HEIGHT: begin
          if (g_hit_q && !prod_q[33] && ({6'd0, prod_q[32:0]} > height_q)) begin
            height_q <= {6'd0, prod_q[32:0]};
          end
        end
        OP_KADD: width_q <= sat_add(width_q, prod_q);
        OP_PREV: begin
          prev_char_q  <= item_q.code[7:0];
          prev_valid_q <= in_range;
        end
        OP_EMIT: begin
          if (!out_busy) begin
            width_q      <= '0;
            height_q     <= '0;
            prev_char_q  <= '0;
            prev_valid_q <= 1'b0;
            miss_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      out_data_q.text_width    <= width_q;
      out_data_q.text_height   <= height_q;
      out_data_q.missing_glyph <= miss_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `include "text_extent_measurer_core_assert.svh"

  `TEM_ASSERT_NOW(a_accept_at_wait, in_valid_i && !in_stall_o, pc_q == STEP_WAIT,
    "input beat taken outside the wait step")
  `TEM_ASSERT_NEXT(a_emit_holds, pc_q == STEP_EMIT && out_valid_q && out_stall_i,
    pc_q == STEP_EMIT, "result overwritten while output stalled")
  `TEM_ASSERT_NEXT(a_emit_clears, pc_q == STEP_EMIT && !out_busy,
    out_valid_q && width_q == '0 && !prev_valid_q && !miss_q,
    "emit did not publish and clear the string state")
  `TEM_ASSERT_NEXT(a_kmul_to_kadd, pc_q == STEP_KMUL, pc_q == STEP_KADD,
    "kerning multiply not followed by its add")

endmodule

// ===== tb/text_extent_measurer_core_tb.sv =====
// self-checking testbench for the text extent measurer core
module text_extent_measurer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tem_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int ALPH_N        = 10;
  localparam int SAT_RUN       = 140;
  localparam int RAND_RUN      = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  text_extent_measurer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // pending request beats and predicted extents
  in_item_t  req_q[$];
  out_item_t extent_q[$];

  // shadow of the font tables, registers and per-string sums
  bit          glyph_ok[0:256];
  shortint     glyph_adv[0:256];
  shortint     glyph_top_s[0:256];
  shortint     glyph_tall_s[0:256];
  logic [7:0]  kern_a[0:255];
  logic [7:0]  kern_b[0:255];
  shortint     kern_amt[0:255];
  logic [15:0] scale_cfg;
  logic [8:0]  kern_limit;
  longint      run_width;
  longint      run_height;
  logic [7:0]  prev_code;
  bit          prev_ok;
  bit          miss_flag;

  logic [7:0]  alph[0:ALPH_N-1];
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          beat_taken;
  int          idle_cycles;
  int          errors;
  int          n_loads;
  int          n_chars;
  int          n_results;
  int          n_writes;
  out_item_t   new_extent;
  out_item_t   want_extent;
  out_item_t   got_extent;

  // saturating add into the width sum
  function automatic void accumulate_width(input longint delta);
    longint s;
    s = run_width + delta;
    if (s > 64'sd549755813887) s = 64'sd549755813887;
    if (s < -64'sd549755813888) s = -64'sd549755813888;
    run_width = s;
  endfunction

  // apply one accepted beat to the shadow state, return 1 when an extent comes out
  function automatic bit measure_char(input in_item_t it, output out_item_t res);
    int     g;
    int     lim;
    int     k;
    bit     found;
    bit     in_range;
    longint sc;
    longint bottom;
    res = '0;
    case (it.req_type)
      REQ_GLYPH: begin
        if (it.code <= 9'd256) begin
          glyph_ok[it.code]     = 1'b1;
          glyph_adv[it.code]    = it.advance;
          glyph_top_s[it.code]  = it.top_offset;
          glyph_tall_s[it.code] = it.glyph_tall;
        end
        return 1'b0;
      end
      REQ_KERN: begin
        kern_a[it.pair_slot]   = it.pair_first;
        kern_b[it.pair_slot]   = it.pair_second;
        kern_amt[it.pair_slot] = it.pair_amount;
        return 1'b0;
      end
      REQ_TEXT: begin
        sc = longint'(scale_cfg);
        in_range = (it.code < 9'd256);
        g = -1;
        if (in_range && glyph_ok[it.code]) g = int'(it.code);
        else if (glyph_ok[256]) g = 256;
        // glyph advance and bottom
        if (g < 0) begin
          miss_flag = 1'b1;
        end else begin
          accumulate_width(longint'(glyph_adv[g]) * sc);
          bottom = (longint'(glyph_top_s[g]) + longint'(glyph_tall_s[g])) * sc;
          if (bottom > run_height) run_height = bottom;
        end
        // kerning against the previous character, lowest slot wins
        if (prev_ok && in_range) begin
          lim = (kern_limit < 9'd256) ? int'(kern_limit) : 256;
          found = 1'b0;
          for (k = 0; k < lim; k++) begin
            if (!found && kern_a[k] == prev_code && kern_b[k] == it.code[7:0]) begin
              accumulate_width(longint'(kern_amt[k]) * sc);
              found = 1'b1;
            end
          end
        end
        prev_code = it.code[7:0];
        prev_ok   = in_range;
        if (!it.last) return 1'b0;
        res.text_width    = run_width[39:0];
        res.text_height   = run_height[38:0];
        res.missing_glyph = miss_flag;
        run_width  = 0;
        run_height = 0;
        prev_code  = 8'd0;
        prev_ok    = 1'b0;
        miss_flag  = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // beat builders, unused fields carry random bits
  function automatic in_item_t noise_beat();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t glyph_beat(input logic [8:0] code, input logic [15:0] adv,
                                          input logic [15:0] top, input logic [15:0] tall);
    in_item_t it;
    it = noise_beat();
    it.req_type   = REQ_GLYPH;
    it.code       = code;
    it.advance    = adv;
    it.top_offset = top;
    it.glyph_tall = tall;
    return it;
  endfunction

  function automatic in_item_t kern_beat(input logic [7:0] slot, input logic [7:0] first,
                                         input logic [7:0] second, input logic [15:0] amt);
    in_item_t it;
    it = noise_beat();
    it.req_type    = REQ_KERN;
    it.pair_slot   = slot;
    it.pair_first  = first;
    it.pair_second = second;
    it.pair_amount = amt;
    return it;
  endfunction

  function automatic in_item_t text_beat(input logic [8:0] code, input logic last);
    in_item_t it;
    it = noise_beat();
    it.req_type = REQ_TEXT;
    it.code     = code;
    it.last     = last;
    return it;
  endfunction

  // code pickers biased toward a small alphabet so kerning pairs hit
  function automatic logic [8:0] pick_text_code();
    int r;
    r = $urandom_range(99);
    if (r < 75) return {1'b0, alph[$urandom_range(ALPH_N-1)]};
    if (r < 90) return 9'($urandom_range(255));
    return 9'($urandom_range(511, 256));
  endfunction

  function automatic logic [8:0] pick_glyph_code();
    int r;
    r = $urandom_range(99);
    if (r < 60) return {1'b0, alph[$urandom_range(ALPH_N-1)]};
    if (r < 85) return 9'($urandom_range(255));
    if (r < 93) return 9'd256;
    return 9'($urandom_range(511, 257));
  endfunction

  function automatic logic [7:0] pick_pair_code();
    if ($urandom_range(99) < 75) return alph[$urandom_range(ALPH_N-1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic in_item_t random_glyph_beat();
    return glyph_beat(pick_glyph_code(), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic in_item_t random_kern_beat(input logic [7:0] slot);
    return kern_beat(slot, pick_pair_code(), pick_pair_code(), 16'($urandom));
  endfunction

  // mostly short strings with random content, some loads and unused requests
  task automatic push_random(input int n);
    int left;
    int r;
    int len;
    int j;
    in_item_t it;
    left = n;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 12) begin
        req_q.push_back(random_glyph_beat());
        left--;
      end else if (r < 20) begin
        req_q.push_back(random_kern_beat(8'($urandom_range(255))));
        left--;
      end else if (r < 23) begin
        it = noise_beat();
        it.req_type = REQ_NONE;
        req_q.push_back(it);
        left--;
      end else begin
        len = $urandom_range(6, 1);
        for (j = 0; j < len; j++) begin
          // occasional table load in the middle of a string
          if ($urandom_range(99) < 5) begin
            if ($urandom_range(1)) req_q.push_back(random_glyph_beat());
            else req_q.push_back(random_kern_beat(8'($urandom_range(255))));
          end
          req_q.push_back(text_beat(pick_text_code(), j == len - 1));
        end
        left -= len;
      end
    end
  endtask

  // register write while the block is idle
  task automatic set_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCALE) scale_cfg = val;
    else kern_limit = val[8:0];
    n_writes++;
  endtask

  // hold off until every beat is in, every extent is out and the core has settled
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (extent_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input driver and output stall, both change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || beat_taken) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // beat monitor, extent checker and watchdog on the rising edge
  always @(posedge clk_i) begin
    beat_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.req_type == REQ_TEXT) n_chars++;
        else n_loads++;
        if (measure_char(in_data_i, new_extent)) extent_q.push_back(new_extent);
      end
      if (out_valid_o && !out_stall_i) begin
        got_extent = out_data_o;
        n_results++;
        if (extent_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected extent, expected none, actual width %0d height %0d miss %0b",
                   $time, got_extent.text_width, got_extent.text_height,
                   got_extent.missing_glyph);
        end else begin
          want_extent = extent_q.pop_front();
          if (got_extent.text_width !== want_extent.text_width) begin
            errors++;
            $display("%0t: text_width expected %0d actual %0d", $time,
                     want_extent.text_width, got_extent.text_width);
          end
          if (got_extent.text_height !== want_extent.text_height) begin
            errors++;
            $display("%0t: text_height expected %0d actual %0d", $time,
                     want_extent.text_height, got_extent.text_height);
          end
          if (got_extent.missing_glyph !== want_extent.missing_glyph) begin
            errors++;
            $display("%0t: missing_glyph expected %0b actual %0b", $time,
                     want_extent.missing_glyph, got_extent.missing_glyph);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int s;
    int j;
    in_item_t it;

    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SCALE;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    beat_taken     = 1'b0;
    idle_cycles    = 0;
    errors         = 0;
    n_loads        = 0;
    n_chars        = 0;
    n_results      = 0;
    n_writes       = 0;
    send_idle_pct  = 30;
    recv_stall_pct = 72;

    // shadow state after reset
    for (s = 0; s <= 256; s++) begin
      glyph_ok[s]     = 1'b0;
      glyph_adv[s]    = 0;
      glyph_top_s[s]  = 0;
      glyph_tall_s[s] = 0;
    end
    for (s = 0; s < 256; s++) begin
      kern_a[s]   = '0;
      kern_b[s]   = '0;
      kern_amt[s] = 0;
    end
    scale_cfg  = SCALE_RESET;
    kern_limit = '0;
    run_width  = 0;
    run_height = 0;
    prev_code  = '0;
    prev_ok    = 1'b0;
    miss_flag  = 1'b0;

    alph[0] = 8'd0;
    alph[1] = 8'd255;
    for (s = 2; s < ALPH_N; s++) alph[s] = 8'($urandom_range(255));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty font, extremes, ignored loads, fallback glyph
    req_q.push_back(text_beat(9'd65, 1'b1));
    req_q.push_back(glyph_beat(9'd0, 16'h7fff, 16'h7fff, 16'h7fff));
    req_q.push_back(glyph_beat(9'd255, 16'h8000, 16'h8000, 16'h8000));
    req_q.push_back(glyph_beat(9'd65, 16'h1000, 16'hfc00, 16'h0c00));
    req_q.push_back(glyph_beat(9'd300, 16'h1234, 16'h5678, 16'h1abc));
    req_q.push_back(glyph_beat(9'd511, 16'h4321, 16'h0876, 16'h0cba));
    it = noise_beat();
    it.req_type = REQ_NONE;
    req_q.push_back(it);
    req_q.push_back(text_beat(9'd0, 1'b0));
    req_q.push_back(text_beat(9'd255, 1'b0));
    req_q.push_back(text_beat(9'd65, 1'b1));
    req_q.push_back(text_beat(9'd200, 1'b1));
    req_q.push_back(glyph_beat(9'd256, 16'hf000, 16'h0000, 16'h1000));
    req_q.push_back(text_beat(9'd200, 1'b0));
    req_q.push_back(text_beat(9'd300, 1'b0));
    req_q.push_back(text_beat(9'd511, 1'b1));
    req_q.push_back(kern_beat(8'd0, 8'd65, 8'd66, 16'h0800));
    req_q.push_back(kern_beat(8'd1, 8'd65, 8'd66, 16'hf800));
    req_q.push_back(kern_beat(8'd2, 8'd0, 8'd255, 16'h8000));
    req_q.push_back(kern_beat(8'd3, 8'd66, 8'd66, 16'h7fff));
    req_q.push_back(glyph_beat(9'd66, 16'h2000, 16'h0000, 16'h2000));
    req_q.push_back(text_beat(9'd65, 1'b0));
    req_q.push_back(text_beat(9'd66, 1'b1));
    wait_drained();

    // directed kerning: lowest slot wins, first char unkerned, repeated pair, chain break
    set_reg(CFG_KERN_COUNT, 16'd4);
    req_q.push_back(text_beat(9'd65, 1'b0));
    req_q.push_back(text_beat(9'd66, 1'b1));
    req_q.push_back(text_beat(9'd66, 1'b1));
    req_q.push_back(text_beat(9'd0, 1'b0));
    req_q.push_back(text_beat(9'd255, 1'b1));
    req_q.push_back(text_beat(9'd66, 1'b0));
    req_q.push_back(text_beat(9'd66, 1'b1));
    req_q.push_back(text_beat(9'd65, 1'b0));
    req_q.push_back(text_beat(9'd300, 1'b0));
    req_q.push_back(text_beat(9'd66, 1'b1));
    req_q.push_back(text_beat(9'd65, 1'b0));
    req_q.push_back(glyph_beat(9'd66, 16'h7fff, 16'h7fff, 16'h0001));
    req_q.push_back(text_beat(9'd66, 1'b1));
    wait_drained();

    // fill every kerning slot, then random traffic
    set_reg(CFG_SCALE, 16'd384);
    for (s = 0; s < 256; s++) req_q.push_back(random_kern_beat(8'(s)));
    push_random(RAND_RUN);
    wait_drained();

    // sender now idles more than the receiver stalls
    send_idle_pct  = 72;
    recv_stall_pct = 30;
    set_reg(CFG_SCALE, 16'd0);
    set_reg(CFG_KERN_COUNT, 16'd256);
    push_random(RAND_RUN);
    wait_drained();

    set_reg(CFG_SCALE, 16'hffff);
    set_reg(CFG_KERN_COUNT, 16'd0);
    push_random(RAND_RUN);
    wait_drained();

    set_reg(CFG_SCALE, 16'($urandom));
    set_reg(CFG_KERN_COUNT, 16'($urandom_range(256)));
    push_random(RAND_RUN);
    wait_drained();

    // no idling from here on
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_reg(CFG_SCALE, 16'd1);
    set_reg(CFG_KERN_COUNT, 16'd1);
    push_random(RAND_RUN);
    wait_drained();

    set_reg(CFG_SCALE, 16'($urandom));
    set_reg(CFG_KERN_COUNT, 16'd256);
    push_random(RAND_RUN);
    wait_drained();

    // long strings that drive the width sum into both saturation limits
    set_reg(CFG_SCALE, 16'hffff);
    set_reg(CFG_KERN_COUNT, 16'd1);
    req_q.push_back(kern_beat(8'd0, 8'd7, 8'd7, 16'h7fff));
    req_q.push_back(glyph_beat(9'd7, 16'h7fff, 16'h7fff, 16'h7fff));
    for (j = 0; j < SAT_RUN; j++) req_q.push_back(text_beat(9'd7, j == SAT_RUN - 1));
    req_q.push_back(kern_beat(8'd0, 8'd9, 8'd9, 16'h8000));
    req_q.push_back(glyph_beat(9'd9, 16'h8000, 16'h1000, 16'h8000));
    for (j = 0; j < SAT_RUN; j++) req_q.push_back(text_beat(9'd9, j == SAT_RUN - 1));
    wait_drained();

    $display("covered %0d characters and %0d load or unused beats, %0d extents checked",
             n_chars, n_loads, n_results);
    $display("over %0d register writes incl. zero and full scale, no and full kerning search",
             n_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
